// File: hdl/owik_pkg.sv
// ----------------------------------------------------------------------------
// owik_pkg: shared types and constants for the omni wheel kinematics unit
// Transaction payloads, register indexes, wheel codes, sine polynomial
// coefficients and small arithmetic helpers.
// ----------------------------------------------------------------------------
package owik_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_BITS_DEF  = 16;

  // Stage count of the sine unit and of the whole datapath
  localparam int SIN_STAGES = 9;
  localparam int NUM_STAGES = 16;

  typedef struct packed {
    logic [2:0]         wheel_index;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic [15:0]        heading;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] wheel_speed;
    logic               bad_index;
  } out_data_t;

  // Configuration register indexes
  localparam logic CFG_WHEEL_OFFSET = 1'b0;
  localparam logic CFG_SPEED_SCALE  = 1'b1;

  localparam logic [30:0] WHEEL_OFFSET_RST = 31'd13107;
  localparam logic [30:0] SPEED_SCALE_RST  = 31'd1310720;

  // Wheel codes
  localparam logic [2:0] WHEEL_FL = 3'd1;
  localparam logic [2:0] WHEEL_FR = 3'd2;
  localparam logic [2:0] WHEEL_RR = 3'd3;
  localparam logic [2:0] WHEEL_RL = 3'd4;

  // Odd sine polynomial on a quarter wave, Q30 coefficients
  localparam logic [30:0] SC1  = 31'd1686629713;
  localparam logic [30:0] SC3  = 31'd693598668;
  localparam logic [30:0] SC5  = 31'd85569305;
  localparam logic [30:0] SC7  = 31'd5026995;
  localparam logic [30:0] SC9  = 31'd172272;
  localparam logic [30:0] SC11 = 31'd3864;

  // One Horner step: c - ((z2 * t) >> 30); z2 never exceeds 2^30
  function automatic logic [30:0] poly_step(input logic [30:0] z2,
                                            input logic [30:0] c,
                                            input logic [30:0] t);
    logic [61:0] p;
    p = 62'(z2) * 62'(t);
    return c - p[60:30];
  endfunction

  // Round a Q32 product to Q16, half away from zero
  function automatic logic signed [47:0] round_q16(input logic signed [63:0] x);
    logic signed [63:0] s;
    s = x + (x[63] ? 64'sh7FFF : 64'sh8000);
    return s[63:16];
  endfunction

endpackage

// File: hdl/owik_sine.sv
// ----------------------------------------------------------------------------
// owik_sine: pipelined fixed-point sine
// Folds the angle onto a quarter wave, evaluates the odd polynomial by
// Horner's rule with one multiplier per stage, then rounds and clamps.
// ----------------------------------------------------------------------------
module owik_sine #(
  parameter int ANGLE_BITS = owik_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_BITS  = owik_pkg::TRIG_BITS_DEF
) (
  input  logic                                clk,
  input  logic [owik_pkg::SIN_STAGES-1:0]     st_en,
  input  logic [ANGLE_BITS-1:0]               angle,
  output logic signed [TRIG_BITS-1:0]         sine
);

  localparam int TFRAC   = TRIG_BITS - 1;
  localparam int PW      = ANGLE_BITS - 1;
  localparam int ZSH     = 32 - ANGLE_BITS;
  localparam int RND_BIT = 29 - TFRAC;
  localparam int SH      = 30 - TFRAC;
  localparam logic [PW-1:0] QUARTER = PW'(1) << (ANGLE_BITS - 2);
  localparam logic [32:0]   RND     = 33'(1) << RND_BIT;
  localparam logic [32:0]   LIM     = (33'(1) << TFRAC) - 33'(1);

  logic [30:0]              z_r   [0:6];
  logic                     neg_r [0:7];
  logic [30:0]              z2_r  [1:5];
  logic [30:0]              t_r   [2:6];
  logic [31:0]              s_r;
  logic signed [TRIG_BITS-1:0] sine_r;

  logic [1:0]    quad;
  logic [PW-1:0] p;
  logic [30:0]   z_nxt;
  logic [61:0]   zsq;
  logic [61:0]   zt;
  logic [32:0]   rr;
  logic [32:0]   rc;
  logic signed [TRIG_BITS-1:0] sine_nxt;

  always_comb begin
    quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
    p    = {1'b0, angle[ANGLE_BITS-3:0]};
    // mirror odd quadrants
    if (quad[0]) begin
      p = QUARTER - p;
    end
    z_nxt = {p, ZSH'(0)};
    zsq   = 62'(z_r[0]) * 62'(z_r[0]);
    zt    = 62'(z_r[6]) * 62'(t_r[6]);
    rr    = ({1'b0, s_r} + RND) >> SH;
    rc    = (rr > LIM) ? LIM : rr;
    sine_nxt = neg_r[7] ? -$signed(TRIG_BITS'(rc)) : $signed(TRIG_BITS'(rc));
  end

  always_ff @(posedge clk) begin
    if (st_en[0]) begin
      z_r[0]   <= z_nxt;
      neg_r[0] <= quad[1];
    end
    if (st_en[1]) begin
      z2_r[1] <= zsq[60:30];
    end
    if (st_en[2]) begin
      t_r[2] <= owik_pkg::poly_step(z2_r[1], owik_pkg::SC9, owik_pkg::SC11);
    end
    if (st_en[3]) begin
      t_r[3] <= owik_pkg::poly_step(z2_r[2], owik_pkg::SC7, t_r[2]);
    end
    if (st_en[4]) begin
      t_r[4] <= owik_pkg::poly_step(z2_r[3], owik_pkg::SC5, t_r[3]);
    end
    if (st_en[5]) begin
      t_r[5] <= owik_pkg::poly_step(z2_r[4], owik_pkg::SC3, t_r[4]);
    end
    if (st_en[6]) begin
      t_r[6] <= owik_pkg::poly_step(z2_r[5], owik_pkg::SC1, t_r[5]);
    end
    if (st_en[7]) begin
      s_r <= zt[61:30];
    end
    if (st_en[8]) begin
      sine_r <= sine_nxt;
    end
    for (int k = 1; k <= 6; k++) begin
      if (st_en[k]) begin
        z_r[k] <= z_r[k-1];
      end
    end
    for (int k = 1; k <= 7; k++) begin
      if (st_en[k]) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (st_en[k]) begin
        z2_r[k] <= z2_r[k-1];
      end
    end
  end

  assign sine = sine_r;

endmodule

// File: hdl/omni_wheel_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics_unit: four-wheel omni drive wheel speed
// Turns a field-frame body velocity, yaw rate and heading into the saturated
// Q16.16 angular speed command of one selected wheel.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while the output is ready and
// presents the results in order. The pipeline holds the sine and cosine
// units, whose polynomial is evaluated by Horner's rule with one
// multiplier per stage, followed by the velocity products, their sum and
// the final scaling multiply. Any stage holding no transaction is filled
// while the output stalls, so up to 16 transactions may be in flight. A
// wheel number outside 1..4 returns a zero speed with bad_index set.
// Write the configuration registers only while no transaction is in flight.
module omni_wheel_inverse_kinematics_unit #(
  parameter int ANGLE_BITS = owik_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_BITS  = owik_pkg::TRIG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  owik_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output owik_pkg::out_data_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [30:0]         cfg_wdata
);

  localparam int NST   = owik_pkg::NUM_STAGES;
  localparam int SST   = owik_pkg::SIN_STAGES;
  localparam int TFRAC = TRIG_BITS - 1;
  localparam int PT    = 32 + TRIG_BITS;
  localparam logic [ANGLE_BITS-1:0] EIGHTH  = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [PT-1:0] HALF = PT'(1) << (TFRAC - 1);

  // Configuration
  logic [30:0] wheel_offset_r;
  logic [30:0] speed_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_offset_r <= owik_pkg::WHEEL_OFFSET_RST;
      speed_scale_r  <= owik_pkg::SPEED_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        owik_pkg::CFG_WHEEL_OFFSET: wheel_offset_r <= cfg_wdata;
        owik_pkg::CFG_SPEED_SCALE:  speed_scale_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or the next one moves
  logic [NST-1:0] vld_r;
  logic [NST:0]   st_en;

  always_comb begin
    st_en[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      st_en[k] = !vld_r[k] || st_en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (st_en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (st_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = st_en[0];
  assign out_valid = vld_r[NST-1];

  // Angles for sine and cosine
  logic [ANGLE_BITS-1:0] head_a;
  logic [ANGLE_BITS-1:0] ang_s;
  logic [ANGLE_BITS-1:0] ang_c;
  logic signed [TRIG_BITS-1:0] sin_s;
  logic signed [TRIG_BITS-1:0] sin_c;

  always_comb begin
    head_a = ANGLE_BITS'(in_data.heading);
    ang_s  = EIGHTH - head_a;
    ang_c  = ang_s + QUARTER;
  end

  owik_sine #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_sin (
    .clk   (clk),
    .st_en (st_en[SST-1:0]),
    .angle (ang_s),
    .sine  (sin_s)
  );

  owik_sine #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_cos (
    .clk   (clk),
    .st_en (st_en[SST-1:0]),
    .angle (ang_c),
    .sine  (sin_c)
  );

  // Side payload travelling alongside the sine units
  logic signed [31:0] vx_r    [0:8];
  logic signed [31:0] vy_r    [0:8];
  logic [2:0]         wheel_r [0:10];
  logic signed [31:0] yaw_r;
  logic signed [63:0] lwp_r;
  logic signed [47:0] lw_r    [2:10];

  // Velocity products and their rounded values: xs, xc, ys, yc
  logic signed [PT-1:0] tp_r  [0:3];
  logic signed [32:0]   tr_r  [0:3];
  logic signed [PT-1:0] tp_nxt [0:3];
  logic signed [32:0]   tr_nxt [0:3];
  logic [PT-1:0]        tsum  [0:3];

  logic signed [47:0] c_r;
  logic               bad_r  [11:14];
  logic [46:0]        m_r;
  logic               neg_r  [12:14];
  logic [53:0]        ph_r;
  logic [54:0]        pl_r;
  logic [63:0]        prod_r;
  owik_pkg::out_data_t out_data_r;

  logic signed [63:0] lwp_nxt;
  logic signed [47:0] c_nxt;
  logic               bad_nxt;
  logic [46:0]        m_nxt;
  logic [63:0]        prod_nxt;
  logic [31:0]        sat;
  owik_pkg::out_data_t out_nxt;

  always_comb begin
    lwp_nxt = 64'($signed({1'b0, wheel_offset_r})) * 64'(yaw_r);

    tp_nxt[0] = PT'(vx_r[8]) * PT'(sin_s);
    tp_nxt[1] = PT'(vx_r[8]) * PT'(sin_c);
    tp_nxt[2] = PT'(vy_r[8]) * PT'(sin_s);
    tp_nxt[3] = PT'(vy_r[8]) * PT'(sin_c);

    // round half away from zero: add half, or half less one when negative
    for (int i = 0; i < 4; i++) begin
      tsum[i]   = tp_r[i] + (tp_r[i][PT-1] ? (HALF - PT'(1)) : HALF);
      tr_nxt[i] = tsum[i][PT-1:TFRAC];
    end

    bad_nxt = 1'b0;
    case (wheel_r[10])
      owik_pkg::WHEEL_FL: c_nxt =  48'(tr_r[0]) + 48'(tr_r[3]) - lw_r[10];
      owik_pkg::WHEEL_FR: c_nxt =  48'(tr_r[1]) - 48'(tr_r[2]) - lw_r[10];
      owik_pkg::WHEEL_RR: c_nxt = -48'(tr_r[0]) - 48'(tr_r[3]) + lw_r[10];
      owik_pkg::WHEEL_RL: c_nxt = -48'(tr_r[1]) + 48'(tr_r[2]) + lw_r[10];
      default: begin
        c_nxt   = '0;
        bad_nxt = 1'b1;
      end
    endcase

    m_nxt = c_r[47] ? 47'(-c_r) : 47'(c_r);

    prod_nxt = {2'b00, ph_r, 8'h00} + 64'((pl_r + 55'h8000) >> 16);

    if (neg_r[14]) begin
      sat = (prod_r > 64'h8000_0000) ? 32'h8000_0000 : prod_r[31:0];
      sat = -sat;
    end else begin
      sat = (prod_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod_r[31:0];
    end
    out_nxt.wheel_speed = bad_r[14] ? 32'sd0 : $signed(sat);
    out_nxt.bad_index   = bad_r[14];
  end

  always_ff @(posedge clk) begin
    if (st_en[0]) begin
      vx_r[0]    <= in_data.vel_x;
      vy_r[0]    <= in_data.vel_y;
      wheel_r[0] <= in_data.wheel_index;
      yaw_r      <= in_data.yaw_rate;
    end
    if (st_en[1]) begin
      lwp_r <= lwp_nxt;
    end
    if (st_en[2]) begin
      lw_r[2] <= owik_pkg::round_q16(lwp_r);
    end
    for (int k = 1; k <= 8; k++) begin
      if (st_en[k]) begin
        vx_r[k] <= vx_r[k-1];
        vy_r[k] <= vy_r[k-1];
      end
    end
    for (int k = 1; k <= 10; k++) begin
      if (st_en[k]) begin
        wheel_r[k] <= wheel_r[k-1];
      end
    end
    for (int k = 3; k <= 10; k++) begin
      if (st_en[k]) begin
        lw_r[k] <= lw_r[k-1];
      end
    end
    if (st_en[9]) begin
      for (int i = 0; i < 4; i++) begin
        tp_r[i] <= tp_nxt[i];
      end
    end
    if (st_en[10]) begin
      for (int i = 0; i < 4; i++) begin
        tr_r[i] <= tr_nxt[i];
      end
    end
    if (st_en[11]) begin
      c_r       <= c_nxt;
      bad_r[11] <= bad_nxt;
    end
    if (st_en[12]) begin
      m_r       <= m_nxt;
      neg_r[12] <= c_r[47];
      bad_r[12] <= bad_r[11];
    end
    if (st_en[13]) begin
      // split the magnitude so each partial product stays within 55 bits
      ph_r      <= 54'(m_r[46:24]) * 54'(speed_scale_r);
      pl_r      <= 55'(m_r[23:0]) * 55'(speed_scale_r);
      neg_r[13] <= neg_r[12];
      bad_r[13] <= bad_r[12];
    end
    if (st_en[14]) begin
      prod_r    <= prod_nxt;
      neg_r[14] <= neg_r[13];
      bad_r[14] <= bad_r[13];
    end
    if (st_en[15]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

  // Checks
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_index |-> out_data.wheel_speed == 32'sd0)
    else $error("bad wheel index with non-zero speed");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("pipeline stalled with output ready");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result lost or changed");

endmodule

// File: tb/sv/owik_checker.sv
// ----------------------------------------------------------------------------
// owik_checker: wheel command predictor and scoreboard
// Watches the register port and both channels of the omni wheel kinematics
// unit, predicts each wheel speed command in fixed point and compares every
// accepted result, in order, with the oldest expected one.
// ----------------------------------------------------------------------------
module owik_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  owik_pkg::in_data_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  owik_pkg::out_data_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [30:0]         cfg_wdata,
  output int                  mismatches,
  output int                  in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          A_BITS  = owik_pkg::ANGLE_BITS_DEF;
  localparam int          T_FRAC  = owik_pkg::TRIG_BITS_DEF - 1;
  localparam int unsigned AMASK   = (1 << A_BITS) - 1;
  localparam int unsigned QUARTER = 1 << (A_BITS - 2);
  localparam logic [63:0] TRIG_LIM = (64'd1 << T_FRAC) - 64'd1;

  logic [30:0]         offset_reg;
  logic [30:0]         scale_reg;
  owik_pkg::out_data_t wheel_cmd_q[$];
  int                  n_bad = 0;
  int                  n_wait = 0;

  assign mismatches = n_bad;
  assign in_flight  = n_wait;

  // Quarter-wave odd polynomial, sign taken from the quadrant
  function automatic longint trig_q15(input logic [31:0] ang);
    logic [31:0] idx, p;
    logic [1:0]  q;
    logic [63:0] z, z2, t, s, r;
    idx = ang & AMASK;
    q   = idx[A_BITS-1 -: 2];
    p   = idx & (QUARTER - 1);
    if (q[0]) begin
      p = QUARTER - p;
    end
    z  = 64'(p) << (32 - A_BITS);
    z2 = (z * z) >> 30;
    t  = 64'(owik_pkg::SC9) - ((z2 * 64'(owik_pkg::SC11)) >> 30);
    t  = 64'(owik_pkg::SC7) - ((z2 * t) >> 30);
    t  = 64'(owik_pkg::SC5) - ((z2 * t) >> 30);
    t  = 64'(owik_pkg::SC3) - ((z2 * t) >> 30);
    t  = 64'(owik_pkg::SC1) - ((z2 * t) >> 30);
    s  = (z * t) >> 30;
    r  = (s + (64'd1 << (29 - T_FRAC))) >> (30 - T_FRAC);
    if (r > TRIG_LIM) begin
      r = TRIG_LIM;
    end
    return q[1] ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint round_half_away(input longint x, input int n);
    logic [63:0] m;
    m = (x < 0) ? 64'(-x) : 64'(x);
    m = (m + (64'd1 << (n - 1))) >> n;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic owik_pkg::out_data_t predict_wheel_cmd(
    input owik_pkg::in_data_t d,
    input logic [30:0]        offset,
    input logic [30:0]        scale
  );
    longint              vx, vy, yr, sn, cs, xs, xc, ys, yc, lw, lin;
    logic [31:0]         h, a;
    logic [63:0]         m, prod;
    owik_pkg::out_data_t r;
    vx = longint'($signed(d.vel_x));
    vy = longint'($signed(d.vel_y));
    yr = longint'($signed(d.yaw_rate));
    h  = 32'(d.heading) & AMASK;
    a  = ((32'd1 << (A_BITS - 3)) - h) & AMASK;
    sn = trig_q15(a);
    cs = trig_q15(a + QUARTER);
    xs = round_half_away(vx * sn, T_FRAC);
    xc = round_half_away(vx * cs, T_FRAC);
    ys = round_half_away(vy * sn, T_FRAC);
    yc = round_half_away(vy * cs, T_FRAC);
    lw = round_half_away(longint'(offset) * yr, 16);
    r.wheel_speed = '0;
    r.bad_index   = 1'b0;
    case (d.wheel_index)
      owik_pkg::WHEEL_FL: lin = xs + yc - lw;
      owik_pkg::WHEEL_FR: lin = xc - ys - lw;
      owik_pkg::WHEEL_RR: lin = -xs - yc + lw;
      owik_pkg::WHEEL_RL: lin = -xc + ys + lw;
      default: begin
        r.bad_index = 1'b1;
        return r;
      end
    endcase
    // Split multiply keeps the product inside 64 bits
    m    = (lin < 0) ? 64'(-lin) : 64'(lin);
    prod = (((m >> 24) * 64'(scale)) << 8)
         + (((m & 64'hFF_FFFF) * 64'(scale) + 64'h8000) >> 16);
    if (lin < 0) begin
      if (prod > 64'h8000_0000) begin
        prod = 64'h8000_0000;
      end
      r.wheel_speed = 32'(-longint'(prod));
    end else begin
      if (prod > 64'h7FFF_FFFF) begin
        prod = 64'h7FFF_FFFF;
      end
      r.wheel_speed = prod[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: wheel command mismatch: %s", $realtime, msg);
    n_bad++;
  endtask

  always @(posedge clk) begin
    owik_pkg::out_data_t want;
    if (!rst_n) begin
      wheel_cmd_q.delete();
      offset_reg = owik_pkg::WHEEL_OFFSET_RST;
      scale_reg  = owik_pkg::SPEED_SCALE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          owik_pkg::CFG_WHEEL_OFFSET: offset_reg = cfg_wdata;
          owik_pkg::CFG_SPEED_SCALE:  scale_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        wheel_cmd_q.push_back(predict_wheel_cmd(in_data, offset_reg, scale_reg));
      end
      if (out_valid && out_ready) begin
        if (wheel_cmd_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result speed %0d bad %0b",
                                    out_data.wheel_speed, out_data.bad_index));
        end else begin
          want = wheel_cmd_q.pop_front();
          if (out_data.wheel_speed !== want.wheel_speed ||
              out_data.bad_index !== want.bad_index) begin
            report_mismatch($sformatf("got speed %0d bad %0b, expected speed %0d bad %0b",
                                      out_data.wheel_speed, out_data.bad_index,
                                      want.wheel_speed, want.bad_index));
          end
        end
      end
    end
    n_wait = wheel_cmd_q.size();
  end

endmodule

// File: tb/sv/tb_omni_wheel_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// tb_omni_wheel_inverse_kinematics_unit: regression for the wheel speed unit
// Drives directed and random wheel commands under several register settings
// and idling patterns, and leaves the checking to a scoreboard alongside.
// ----------------------------------------------------------------------------
module tb_omni_wheel_inverse_kinematics_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [30:0] REG_MAX     = 31'h7FFF_FFFF;
  localparam int          CHUNKS      = 16;
  localparam int          CHUNK_ITEMS = 66;

  localparam logic [2:0] W_FL = owik_pkg::WHEEL_FL;
  localparam logic [2:0] W_FR = owik_pkg::WHEEL_FR;
  localparam logic [2:0] W_RR = owik_pkg::WHEEL_RR;
  localparam logic [2:0] W_RL = owik_pkg::WHEEL_RL;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  owik_pkg::in_data_t  in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  owik_pkg::out_data_t out_data;
  logic                cfg_we;
  logic                cfg_addr;
  logic [30:0]         cfg_wdata;
  int                  mismatches;
  int                  in_flight;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  omni_wheel_inverse_kinematics_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  owik_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic owik_pkg::in_data_t wheel_cmd(input logic [2:0] w,
                                                   input logic [31:0] vx,
                                                   input logic [31:0] vy,
                                                   input logic [31:0] yr,
                                                   input logic [15:0] h);
    owik_pkg::in_data_t d;
    d.wheel_index = w;
    d.vel_x       = vx;
    d.vel_y       = vy;
    d.yaw_rate    = yr;
    d.heading     = h;
    return d;
  endfunction

  // Mix of extremes, full-range words and small signed values
  function automatic logic [31:0] rand_q16();
    logic signed [31:0] s;
    int                 sh;
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return $urandom;
      default: begin
        s  = $urandom;
        sh = 32 - $urandom_range(1, 24);
        s  = s <<< sh;
        return s >>> sh;
      end
    endcase
  endfunction

  function automatic logic [30:0] rand_reg();
    logic [30:0] v;
    v = 31'($urandom);
    return v >> $urandom_range(30);
  endfunction

  function automatic owik_pkg::in_data_t rand_cmd();
    logic [2:0]  w;
    logic [15:0] h;
    int          pick;
    if ($urandom_range(9) != 0) begin
      w = 3'($urandom_range(1, 4));
    end else begin
      pick = $urandom_range(3);
      w = (pick == 0) ? 3'd0 : 3'(pick + 4);
    end
    if ($urandom_range(3) == 0) begin
      // land on or next to an octant boundary
      h = 16'(($urandom_range(7) << 13) + $urandom_range(2) - 1);
    end else begin
      h = 16'($urandom);
    end
    return wheel_cmd(w, rand_q16(), rand_q16(), rand_q16(), h);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(input owik_pkg::in_data_t d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic set_gains(input logic [30:0] offset, input logic [30:0] scale);
    cfg_we    <= 1'b1;
    cfg_addr  <= owik_pkg::CFG_WHEEL_OFFSET;
    cfg_wdata <= offset;
    @(negedge clk);
    cfg_addr  <= owik_pkg::CFG_SPEED_SCALE;
    cfg_wdata <= scale;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = owik_pkg::CFG_WHEEL_OFFSET;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed commands under the reset gains
    send_cmd(wheel_cmd(W_FL, 32'h1_0000, 32'h0, 32'h0, 16'h0000));
    send_cmd(wheel_cmd(W_FR, 32'h0, 32'h1_0000, 32'h0, 16'h0000));
    send_cmd(wheel_cmd(W_RR, 32'h0, 32'h0, 32'h1_0000, 16'h0000));
    send_cmd(wheel_cmd(W_RL, 32'h1_0000, 32'h1_0000, 32'h1_0000, 16'h4000));
    send_cmd(wheel_cmd(3'd0, 32'h1234_5678, 32'hCAFE_0000, 32'h0001_0000, 16'h1000));
    send_cmd(wheel_cmd(3'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
    send_cmd(wheel_cmd(3'd6, 32'h0002_0000, 32'hFFFF_0000, 32'h0, 16'h8000));
    send_cmd(wheel_cmd(3'd7, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 16'h2000));
    send_cmd(wheel_cmd(W_FL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h2000));
    send_cmd(wheel_cmd(W_FR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h6000));
    send_cmd(wheel_cmd(W_RR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF));
    send_cmd(wheel_cmd(W_RL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hA000));
    send_cmd(wheel_cmd(W_FL, 32'h0, 32'h0, 32'h0, 16'hE000));
    send_cmd(wheel_cmd(W_FR, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 16'hC000));
    send_cmd(wheel_cmd(W_RR, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 16'h8000));
    send_cmd(wheel_cmd(W_RL, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_4000, 16'h1FFF));
    send_cmd(wheel_cmd(W_FL, 32'h0001_0000, 32'h0001_0000, 32'h0, 16'h3FFF));
    send_cmd(wheel_cmd(W_RL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001));
    wait_quiet();

    // Random commands in chunks; gains change only while the unit is empty
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk / 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      case (chunk)
        1:  set_gains(REG_MAX, REG_MAX);
        6:  set_gains(31'd0, REG_MAX);
        11: set_gains(REG_MAX, 31'd0);
        14: set_gains(31'd0, 31'd0);
        15: set_gains(owik_pkg::WHEEL_OFFSET_RST, owik_pkg::SPEED_SCALE_RST);
        default: set_gains(rand_reg(), rand_reg());
      endcase
      repeat (CHUNK_ITEMS) send_cmd(rand_cmd());
      wait_quiet();
    end

    stall_pct = 0;
    repeat (owik_pkg::NUM_STAGES + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("omni_wheel_inverse_kinematics_unit regression: pass");
    end else begin
      $display("omni_wheel_inverse_kinematics_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("omni_wheel_inverse_kinematics_unit regression: fail");
    $finish;
  end

endmodule

// File: omni_wheel_inverse_kinematics_unit.f
hdl/owik_pkg.sv
hdl/owik_sine.sv
hdl/omni_wheel_inverse_kinematics_unit.sv
tb/sv/owik_checker.sv
tb/sv/tb_omni_wheel_inverse_kinematics_unit.sv
